// ===== hdl/dcp_pkg.sv =====
`timescale 1ns / 1ps
package dcp_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_STRENGTH_CAP   = 3'd0,
    REG_FOCUS_DISTANCE = 3'd1,
    REG_APERTURE_GAIN  = 3'd2,
    REG_FOCAL_LEN      = 3'd3,
    REG_F_STOP         = 3'd4
  } dcp_reg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int BLUR_W      = 16;
  localparam int PEAK_W      = 13;
  localparam int NUM_CORNERS = 4;

  // Register stages in one corner unit and in the summary stage.
  localparam int CU_STAGES  = 24;
  localparam int SUM_STAGES = 2;

  // Minimum spread and peak for a usable plan, in hundredths of a pixel.
  localparam logic [BLUR_W-1:0] MIN_SPREAD = 16'd125;
  localparam logic [BLUR_W-1:0] MIN_PEAK   = 16'd30;

  // floor(v / 10) == (v * RECIP_10) >> RECIP_SH for every v below 2**18.
  localparam logic [15:0] RECIP_10 = 16'd52429;
  localparam int          RECIP_SH = 19;

  typedef struct packed {
    logic [15:0] strength_cap;
    logic [23:0] focus_distance;
    logic [15:0] aperture_gain;
    logic [23:0] focal_len;
    logic [15:0] f_stop;
  } dcp_cfg_t;

endpackage

// ===== hdl/dcp_if.sv =====
`timescale 1ns / 1ps
interface dcp_corner_if #(parameter int DEPTH_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [DEPTH_BITS-1:0] corner_depth_0;
  logic signed [DEPTH_BITS-1:0] corner_depth_1;
  logic signed [DEPTH_BITS-1:0] corner_depth_2;
  logic signed [DEPTH_BITS-1:0] corner_depth_3;

  modport source (output valid, corner_depth_0, corner_depth_1, corner_depth_2,
                  corner_depth_3, input ready);
  modport sink (input valid, corner_depth_0, corner_depth_1, corner_depth_2,
                corner_depth_3, output ready);
endinterface

interface dcp_plan_if;
  logic        valid;
  logic        ready;
  logic [15:0] corner_blur_0;
  logic [15:0] corner_blur_1;
  logic [15:0] corner_blur_2;
  logic [15:0] corner_blur_3;
  logic [12:0] peak_amount;
  logic        plan_valid;

  modport source (output valid, corner_blur_0, corner_blur_1, corner_blur_2,
                  corner_blur_3, peak_amount, plan_valid, input ready);
  modport sink (input valid, corner_blur_0, corner_blur_1, corner_blur_2,
                corner_blur_3, peak_amount, plan_valid, output ready);
endinterface

// ===== hdl/dof_corner_coc_planner.sv =====
`timescale 1ns / 1ps
// Depth-of-field corner planner. Each request carries the four signed corner
// depths of a layer and produces one plan: a blur radius per corner in
// hundredths of a pixel, the largest radius rounded to tenths, and a flag that
// says whether the plan is worth using (spread of at least 1.25 px and peak of
// at least 0.3 px). With f_stop nonzero the thin-lens circle of confusion is
// used, and a corner at or behind the lens, or a focus at or inside the focal
// length, takes the full strength cap; with f_stop zero a linear defocus model
// is used. All radii are rounded to the nearest hundredth, halves upward, and
// capped at strength_cap. The block accepts one request per clock while the
// output is not stalled. Each of the four corner units holds a 17-step
// restoring divider, one quotient bit per stage. Back-pressure on the plan
// channel holds the whole pipeline. Configuration is written through wr_en,
// wr_index and wr_data and must only change while no request is in flight.
module dof_corner_coc_planner
  import dcp_pkg::*;
#(
  parameter int DEPTH_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  dcp_corner_if.sink             corners,
  dcp_plan_if.source             plan
);

  localparam int LAT = CU_STAGES + SUM_STAGES;

  dcp_cfg_t          cfg;
  logic              vld [LAT];
  logic              ce;
  logic [BLUR_W-1:0] blur     [NUM_CORNERS];
  logic [BLUR_W-1:0] blur_out [NUM_CORNERS];
  logic signed [DEPTH_BITS-1:0] depth [NUM_CORNERS];

  // The pipeline advances whenever the last stage is empty or being taken.
  assign ce            = !vld[LAT-1] || plan.ready;
  assign corners.ready = ce;
  assign plan.valid    = vld[LAT-1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strength_cap   <= 16'd0;
      cfg.focus_distance <= 24'd256;
      cfg.aperture_gain  <= 16'd0;
      cfg.focal_len      <= 24'd256;
      cfg.f_stop         <= 16'd0;
    end else if (wr_en) begin
      unique case (dcp_reg_t'(wr_index))
        REG_STRENGTH_CAP:   cfg.strength_cap   <= wr_data[15:0];
        REG_FOCUS_DISTANCE: cfg.focus_distance <= wr_data;
        REG_APERTURE_GAIN:  cfg.aperture_gain  <= wr_data[15:0];
        REG_FOCAL_LEN:      cfg.focal_len      <= wr_data;
        REG_F_STOP:         cfg.f_stop         <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (ce) begin
      vld[0] <= corners.valid;
      for (int i = 1; i < LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  assign depth[0] = corners.corner_depth_0;
  assign depth[1] = corners.corner_depth_1;
  assign depth[2] = corners.corner_depth_2;
  assign depth[3] = corners.corner_depth_3;

  // One corner unit per corner, all stepping together.
  for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_corner
    dcp_corner #(
      .DEPTH_BITS (DEPTH_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_corner (
      .clk   (clk),
      .ce    (ce),
      .cfg   (cfg),
      .depth (depth[c]),
      .blur  (blur[c])
    );
  end

  // Peak, spread check and output register.
  dcp_summary u_summary (
    .clk      (clk),
    .ce       (ce),
    .blur_in  (blur),
    .blur_out (blur_out),
    .peak     (plan.peak_amount),
    .usable   (plan.plan_valid)
  );

  assign plan.corner_blur_0 = blur_out[0];
  assign plan.corner_blur_1 = blur_out[1];
  assign plan.corner_blur_2 = blur_out[2];
  assign plan.corner_blur_3 = blur_out[3];

endmodule

// ===== hdl/dcp_corner.sv =====
`timescale 1ns / 1ps
module dcp_corner
  import dcp_pkg::*;
#(
  parameter int DEPTH_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         ce,
  input  dcp_cfg_t                     cfg,
  input  logic signed [DEPTH_BITS-1:0] depth,
  output logic [BLUR_W-1:0]            blur
);

  localparam int DW   = ((DEPTH_BITS - 1 > 24) ? DEPTH_BITS - 1 : 24) + 1;
  localparam int LSH  = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
  localparam int DSH  = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
  localparam int NDW  = 16 + DEPTH_BITS - 1;
  localparam int NDH  = NDW - 24;
  localparam int NW0  = 48 + DW + LSH;
  localparam int NW   = NW0 + 7;
  localparam int DENW = NDW + 24 + DSH;
  localparam int XW   = ((NW + 1 > DENW) ? NW + 1 : DENW) + 1;
  localparam int WW   = (XW > DENW + 17) ? XW : DENW + 17;
  localparam int QSTEPS = 17;
  localparam logic [23:0] ONE = 24'(1) << FRAC_BITS;

  // Input register
  logic signed [DEPTH_BITS-1:0] d_r;

  // Distance, lens terms and linear divisor
  logic signed [DW:0]   dd, sd, diff;
  logic [23:0]          f_eff;
  logic [DW-1:0]        dist_1;
  logic [47:0]          ff_1;
  logic [NDW-1:0]       nd_1;
  logic [23:0]          sf_1;
  logic [31:0]          lden_1;
  logic                 lens_1, fall_1;

  // Partial products
  logic [24+DW-1:0]     plo_2, phi_2;
  logic [47:0]          qlo_2;
  logic [NDH+23:0]      qhi_2;
  logic [DW+15:0]       lnum_2;
  logic [31:0]          lden_2;
  logic                 lens_2, fall_2;

  // Numerator and denominator
  logic [NW0-1:0]       num_3;
  logic [DENW-1:0]      den_3;
  logic                 force_3;
  logic [NW-1:0]        n100_4;
  logic [DENW-1:0]      den_4;
  logic                 force_4;

  // Divider stages: stage 0 is loaded with 200*num+den and 2*den
  logic [WW-1:0]        rem [0:QSTEPS];
  logic [DENW:0]        dv  [0:QSTEPS];
  logic [BLUR_W-1:0]    qt  [0:QSTEPS];
  logic                 sat [0:QSTEPS];

  logic [NW0-1:0]       lens_num;
  logic [DENW-1:0]      lens_den;

  always_comb begin
    dd    = (DW+1)'(d_r);
    sd    = (DW+1)'($signed({1'b0, cfg.focus_distance}));
    diff  = dd - sd;
    f_eff = (cfg.focal_len == 24'd0) ? 24'd1 : cfg.focal_len;
  end

  assign lens_num = ((NW0'(phi_2) << 24) + NW0'(plo_2)) << LSH;
  assign lens_den = ((DENW'(qhi_2) << 24) + DENW'(qlo_2)) << DSH;

  always_ff @(posedge clk) begin
    if (ce) begin
      d_r <= depth;

      dist_1 <= (diff < 0) ? DW'(-diff) : DW'(diff);
      ff_1   <= 48'(f_eff) * 48'(f_eff);
      nd_1   <= NDW'(cfg.f_stop) * NDW'(d_r[DEPTH_BITS-2:0]);
      sf_1   <= cfg.focus_distance - f_eff;
      lden_1 <= {((cfg.focus_distance > ONE) ? cfg.focus_distance : ONE), 8'd0};
      lens_1 <= (cfg.f_stop != 16'd0);
      fall_1 <= (cfg.focus_distance <= f_eff) || (d_r <= 0);

      plo_2  <= (24+DW)'(ff_1[23:0]) * (24+DW)'(dist_1);
      phi_2  <= (24+DW)'(ff_1[47:24]) * (24+DW)'(dist_1);
      qlo_2  <= 48'(nd_1[23:0]) * 48'(sf_1);
      qhi_2  <= (NDH+24)'(nd_1[NDW-1:24]) * (NDH+24)'(sf_1);
      lnum_2 <= (DW+16)'(dist_1) * (DW+16)'(cfg.aperture_gain);
      lden_2 <= lden_1;
      lens_2 <= lens_1;
      fall_2 <= fall_1;

      num_3   <= lens_2 ? lens_num : NW0'(lnum_2);
      den_3   <= lens_2 ? lens_den : DENW'(lden_2);
      force_3 <= lens_2 && fall_2;

      // Multiply by 100 as 64 + 32 + 4.
      n100_4  <= (NW'(num_3) << 6) + (NW'(num_3) << 5) + (NW'(num_3) << 2);
      den_4   <= den_3;
      force_4 <= force_3;

      rem[0] <= (WW'(n100_4) << 1) + WW'(den_4);
      dv[0]  <= {den_4, 1'b0};
      qt[0]  <= '0;
      sat[0] <= force_4;
    end
  end

  for (genvar j = 0; j < QSTEPS; j++) begin : g_div
    logic [WW-1:0] trial;
    logic          ge;

    assign trial = WW'(dv[j]) << (QSTEPS - 1 - j);
    assign ge    = (rem[j] >= trial);

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[j+1] <= ge ? rem[j] - trial : rem[j];
        dv[j+1]  <= dv[j];
        if (j == 0) begin
          // The top step only detects a quotient beyond the 16-bit range.
          qt[j+1]  <= qt[j];
          sat[j+1] <= sat[j] || ge;
        end else begin
          qt[j+1]  <= qt[j] | (BLUR_W'(ge) << (QSTEPS - 1 - j));
          sat[j+1] <= sat[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (sat[QSTEPS] || (qt[QSTEPS] > cfg.strength_cap)) begin
        blur <= cfg.strength_cap;
      end else begin
        blur <= qt[QSTEPS];
      end
    end
  end

endmodule

// ===== hdl/dcp_summary.sv =====
`timescale 1ns / 1ps
module dcp_summary
  import dcp_pkg::*;
(
  input  logic              clk,
  input  logic              ce,
  input  logic [BLUR_W-1:0] blur_in  [NUM_CORNERS],
  output logic [BLUR_W-1:0] blur_out [NUM_CORNERS],
  output logic [PEAK_W-1:0] peak,
  output logic              usable
);

  logic [BLUR_W-1:0] b_r [NUM_CORNERS];
  logic [BLUR_W-1:0] mx_r, mn_r;
  logic [BLUR_W-1:0] mx01, mx23, mn01, mn23;
  logic [32:0]       scaled;

  always_comb begin
    mx01   = (blur_in[1] > blur_in[0]) ? blur_in[1] : blur_in[0];
    mx23   = (blur_in[3] > blur_in[2]) ? blur_in[3] : blur_in[2];
    mn01   = (blur_in[1] < blur_in[0]) ? blur_in[1] : blur_in[0];
    mn23   = (blur_in[3] < blur_in[2]) ? blur_in[3] : blur_in[2];
    scaled = (33'(mx_r) + 33'd5) * 33'(RECIP_10);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      b_r      <= blur_in;
      mx_r     <= (mx23 > mx01) ? mx23 : mx01;
      mn_r     <= (mn23 < mn01) ? mn23 : mn01;
      blur_out <= b_r;
      peak     <= scaled[RECIP_SH+PEAK_W-1:RECIP_SH];
      usable   <= ((mx_r - mn_r) >= MIN_SPREAD) && (mx_r >= MIN_PEAK);
    end
  end

endmodule

// ===== hdl/dcp_checker.sv =====
`timescale 1ns / 1ps
module dcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] blur_0,
  input logic [15:0] blur_1,
  input logic [15:0] blur_2,
  input logic [15:0] blur_3,
  input logic [12:0] peak,
  input logic        usable
);

  logic [16:0] peak_hi;

  assign peak_hi = 17'(peak) * 17'd10 + 17'd4;

  // A stalled plan stays offered.
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("plan withdrawn while stalled");

  // A stalled output freezes the pipeline, so no request may enter.
  a_backpressure : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while output stalled");

  // A usable plan has a peak of at least 0.3 px.
  a_usable_peak : assert property (@(posedge clk) disable iff (rst)
    out_valid && usable |-> peak >= 13'd3)
    else $error("usable plan with too small a peak");

  // The peak, rounded to tenths, is not below any corner radius.
  a_peak_bound : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> peak_hi >= 17'(blur_0) && peak_hi >= 17'(blur_1) &&
                  peak_hi >= 17'(blur_2) && peak_hi >= 17'(blur_3))
    else $error("peak below a corner radius");

endmodule

bind dof_corner_coc_planner dcp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (corners.ready),
  .out_valid (plan.valid),
  .out_ready (plan.ready),
  .blur_0    (plan.corner_blur_0),
  .blur_1    (plan.corner_blur_1),
  .blur_2    (plan.corner_blur_2),
  .blur_3    (plan.corner_blur_3),
  .peak      (plan.peak_amount),
  .usable    (plan.plan_valid)
);
